### src/epo_pkg.sv
// Shared types and constants for the Euler path option payoff block.
package epo_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int REG_IDX_LSB = 2;

    localparam int FACTOR_W    = 32;
    localparam int PRICE_W     = 31;
    localparam int PAYOFF_W    = 31;
    localparam int FINAL_W     = 32;
    localparam int ACC_W       = 63;
    localparam int CNT_W       = 32;
    localparam int SQUARE_W    = 62;
    localparam int TERM_W      = 62;
    localparam int SUM_W       = 64;
    localparam int DIGIT_W     = 32;

    localparam int FACTOR_FRAC = 30;
    localparam int SAMPLE_FRAC = 12;
    localparam int TERM_SHIFT  = 60;

    localparam logic [PRICE_W-1:0] START_RESET  = 31'd6553600;
    localparam logic [PRICE_W-1:0] STRIKE_RESET = 31'd6553600;
    localparam int                 STEPS_RESET  = 300;

    typedef enum logic [2:0] {
        REG_DRIFT     = 3'd0,
        REG_DIFFUSION = 3'd1,
        REG_START     = 3'd2,
        REG_STRIKE    = 3'd3,
        REG_KIND      = 3'd4,
        REG_STEPS     = 3'd5
    } reg_index_t;

    typedef enum logic {
        KIND_CALL = 1'b0,
        KIND_PUT  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        SEL_DRIFT     = 2'd0,
        SEL_DIFFUSION = 2'd1,
        SEL_SAMPLE    = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] drift;
        logic [FACTOR_W-1:0] diffusion;
        logic [PRICE_W-1:0]  start_price;
        logic [PRICE_W-1:0]  strike_price;
        kind_t               kind;
    } cfg_t;

    typedef struct packed {
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     load_sample;
        logic     cap_drift;
        logic     cap_term;
        logic     update;
        logic     form_payoff;
        logic     form_square;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic path_end;
        logic out_free;
    } status_t;

endpackage

### src/epo_regs.sv
// Configuration register file behind the APB-style port.
module epo_regs #(
    parameter int STEP_COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [epo_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [epo_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [epo_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output epo_pkg::cfg_t                       cfg,
    output logic [STEP_COUNT_WIDTH-1:0]         steps
);

    epo_pkg::cfg_t                 cfg_reg;
    logic [STEP_COUNT_WIDTH-1:0]   steps_reg;
    epo_pkg::reg_index_t           idx;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = epo_pkg::reg_index_t'(paddr[epo_pkg::CFG_ADDR_W-1:epo_pkg::REG_IDX_LSB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drift        <= '0;
            cfg_reg.diffusion    <= '0;
            cfg_reg.start_price  <= epo_pkg::START_RESET;
            cfg_reg.strike_price <= epo_pkg::STRIKE_RESET;
            cfg_reg.kind         <= epo_pkg::KIND_CALL;
            steps_reg            <= STEP_COUNT_WIDTH'(epo_pkg::STEPS_RESET);
        end else if (wr_en) begin
            unique case (idx)
                epo_pkg::REG_DRIFT:     cfg_reg.drift <= pwdata;
                epo_pkg::REG_DIFFUSION: cfg_reg.diffusion <= pwdata;
                epo_pkg::REG_START:     cfg_reg.start_price <= pwdata[epo_pkg::PRICE_W-1:0];
                epo_pkg::REG_STRIKE:    cfg_reg.strike_price <= pwdata[epo_pkg::PRICE_W-1:0];
                epo_pkg::REG_KIND:      cfg_reg.kind <= epo_pkg::kind_t'(pwdata[0]);
                epo_pkg::REG_STEPS:     steps_reg <= pwdata[STEP_COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            epo_pkg::REG_DRIFT:     prdata = cfg_reg.drift;
            epo_pkg::REG_DIFFUSION: prdata = cfg_reg.diffusion;
            epo_pkg::REG_START:     prdata = {1'b0, cfg_reg.start_price};
            epo_pkg::REG_STRIKE:    prdata = {1'b0, cfg_reg.strike_price};
            epo_pkg::REG_KIND:      prdata = epo_pkg::CFG_DATA_W'(cfg_reg.kind);
            epo_pkg::REG_STEPS:     prdata = epo_pkg::CFG_DATA_W'(steps_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg   = cfg_reg;
    assign steps = steps_reg;

endmodule

### src/epo_mul.sv
// Digit-serial signed multiplier: 32-bit digits of a times b, top digit first.
module epo_mul #(
    parameter int A_W = 34
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [A_W-1:0]          a,
    input  logic signed [epo_pkg::DIGIT_W-1:0] b,
    output logic                           done,
    output logic signed [((A_W + epo_pkg::DIGIT_W - 1) / epo_pkg::DIGIT_W) * epo_pkg::DIGIT_W
                         + epo_pkg::DIGIT_W - 1:0] product
);

    localparam int DW     = epo_pkg::DIGIT_W;
    localparam int NDIG   = (A_W + DW - 1) / DW;
    localparam int PAD_W  = NDIG * DW;
    localparam int P_W    = PAD_W + DW;
    localparam int CNT_BW = $clog2(NDIG + 1);

    logic signed [PAD_W-1:0]  a_sh_reg;
    logic signed [DW-1:0]     b_reg;
    logic [CNT_BW-1:0]        cnt_reg;
    logic                     first_reg;
    logic                     pp_vld_reg;
    logic                     pp_last_reg;
    logic                     done_reg;
    logic signed [2*DW:0]     pp_reg;
    logic signed [P_W-1:0]    acc_reg;
    logic [DW-1:0]            top_bits;
    logic signed [DW:0]       digit;
    logic signed [2*DW:0]     pp_next;
    logic signed [P_W-1:0]    acc_next;

    assign top_bits = a_sh_reg[PAD_W-1 -: DW];
    // top digit carries the sign, lower digits are plain magnitudes
    assign digit    = first_reg ? {top_bits[DW-1], top_bits} : {1'b0, top_bits};
    assign pp_next  = digit * b_reg;
    assign acc_next = (acc_reg <<< DW) + P_W'(pp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            if (start) begin
                cnt_reg <= CNT_BW'(NDIG);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            pp_vld_reg <= !start && (cnt_reg != '0);
            done_reg   <= pp_vld_reg && pp_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_sh_reg  <= PAD_W'(a);
            b_reg     <= b;
            first_reg <= 1'b1;
            acc_reg   <= '0;
        end else begin
            if (cnt_reg != '0) begin
                pp_reg      <= pp_next;
                pp_last_reg <= (cnt_reg == CNT_BW'(1));
                a_sh_reg    <= a_sh_reg << DW;
                first_reg   <= 1'b0;
            end
            if (pp_vld_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### src/epo_dp.sv
// Datapath: Euler step arithmetic, payoff, accumulators and output register.
module epo_dp #(
    parameter int VALUE_WIDTH      = 32,
    parameter int SAMPLE_WIDTH     = 16,
    parameter int STEP_COUNT_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  epo_pkg::cmd_t                           cmd,
    output epo_pkg::status_t                        status,
    input  epo_pkg::cfg_t                           cfg,
    input  logic [STEP_COUNT_WIDTH-1:0]             steps,
    input  logic signed [SAMPLE_WIDTH-1:0]          s_normal_sample,
    input  logic                                    m_ready,
    output logic                                    m_valid,
    output logic [epo_pkg::PAYOFF_W-1:0]            m_path_payoff,
    output logic signed [epo_pkg::FINAL_W-1:0]      m_final_value,
    output logic [epo_pkg::ACC_W-1:0]               m_payoff_total,
    output logic [epo_pkg::ACC_W-1:0]               m_payoff_square_total,
    output logic [epo_pkg::CNT_W-1:0]               m_paths_done,
    output logic [epo_pkg::CNT_W-1:0]               m_origin_hit_total
);

    localparam int DW    = epo_pkg::DIGIT_W;
    localparam int SUM_W = epo_pkg::SUM_W;
    localparam int A_W   = VALUE_WIDTH + 2;
    localparam int P_W   = ((A_W + DW - 1) / DW) * DW + DW;
    localparam int SCW   = STEP_COUNT_WIDTH;

    localparam logic signed [SUM_W-1:0] VMAX   = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [SUM_W-1:0] VMIN   = -VMAX - 64'sd1;
    localparam logic signed [SUM_W-1:0] FV_MAX = 64'sd2147483647;
    localparam logic signed [SUM_W-1:0] FV_MIN = -64'sd2147483648;
    localparam logic signed [SUM_W-1:0] PAY_MAX = 64'sd2147483647;
    localparam logic signed [P_W-1:0]   TERM_HI = P_W'(64'sd1 <<< epo_pkg::TERM_SHIFT);
    localparam logic signed [P_W-1:0]   TERM_LO = -TERM_HI;

    // state and working registers
    logic signed [SAMPLE_WIDTH-1:0]     sample_reg;
    logic signed [VALUE_WIDTH-1:0]      cur_val_reg;
    logic [SCW-1:0]                     step_idx_reg;
    logic signed [A_W-1:0]              drift_term_reg;
    logic signed [epo_pkg::TERM_W-1:0]  diff_term_reg;
    logic [epo_pkg::PAYOFF_W-1:0]       upay_reg;
    logic [epo_pkg::SQUARE_W-1:0]       sq_reg;
    logic [epo_pkg::ACC_W-1:0]          pay_acc_reg;
    logic [epo_pkg::ACC_W-1:0]          sq_acc_reg;
    logic [epo_pkg::CNT_W-1:0]          paths_reg;
    logic [epo_pkg::CNT_W-1:0]          origin_reg;
    logic                               m_valid_reg;
    logic [epo_pkg::PAYOFF_W-1:0]       m_pay_reg;
    logic signed [epo_pkg::FINAL_W-1:0] m_final_reg;
    logic [epo_pkg::CNT_W-1:0]          m_origin_reg;

    // combinational
    logic signed [SUM_W-1:0]            start_wide;
    logic signed [VALUE_WIDTH-1:0]      start_val;
    logic signed [VALUE_WIDTH-1:0]      base;
    logic signed [A_W-1:0]              mul_a;
    logic signed [DW-1:0]               mul_b;
    logic                               mul_done;
    logic signed [P_W-1:0]              mul_p;
    logic signed [P_W-1:0]              p_q30;
    logic signed [P_W-1:0]              p_q12;
    logic signed [P_W-1:0]              term_clamped;
    logic signed [A_W-1:0]              d_val;
    logic signed [SUM_W-1:0]            sum;
    logic signed [SUM_W-1:0]            nv_sat;
    logic [SCW-1:0]                     step_inc;
    logic [SCW-1:0]                     steps_eff;
    logic                               path_end;
    logic signed [SUM_W-1:0]            cur_wide;
    logic signed [SUM_W-1:0]            strike_wide;
    logic signed [SUM_W-1:0]            pay;
    logic [epo_pkg::PAYOFF_W-1:0]       upay_next;
    logic [epo_pkg::SQUARE_W-1:0]       sq_next;
    logic [SUM_W-1:0]                   pay_sum;
    logic [SUM_W-1:0]                   sq_sum;
    logic [epo_pkg::ACC_W-1:0]          pay_acc_next;
    logic [epo_pkg::ACC_W-1:0]          sq_acc_next;
    logic signed [epo_pkg::FINAL_W-1:0] final_next;

    // start price clipped to the value range
    assign start_wide = $signed({{(SUM_W - epo_pkg::PRICE_W){1'b0}}, cfg.start_price});
    assign start_val  = (start_wide > VMAX) ? VALUE_WIDTH'(VMAX) : VALUE_WIDTH'(start_wide);
    assign base       = (step_idx_reg == '0) ? start_val : cur_val_reg;

    assign p_q30 = mul_p >>> epo_pkg::FACTOR_FRAC;
    assign p_q12 = mul_p >>> epo_pkg::SAMPLE_FRAC;
    assign d_val = A_W'(p_q30);

    always_comb begin
        case (cmd.mul_sel)
            epo_pkg::SEL_DRIFT: begin
                mul_a = A_W'(base);
                mul_b = $signed(cfg.drift);
            end
            epo_pkg::SEL_DIFFUSION: begin
                mul_a = A_W'(base);
                mul_b = $signed(cfg.diffusion);
            end
            epo_pkg::SEL_SAMPLE: begin
                mul_a = d_val;
                mul_b = DW'(sample_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    epo_mul #(
        .A_W (A_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // clamp the diffusion term magnitude
    assign term_clamped = (p_q12 > TERM_HI) ? TERM_HI :
                          (p_q12 < TERM_LO) ? TERM_LO : p_q12;

    assign sum    = SUM_W'(base) + SUM_W'(drift_term_reg) + SUM_W'(diff_term_reg);
    assign nv_sat = (sum > VMAX) ? VMAX : ((sum < VMIN) ? VMIN : sum);

    assign step_inc  = step_idx_reg + 1'b1;
    assign steps_eff = (steps == '0) ? SCW'(1) : steps;
    assign path_end  = !(step_inc < steps_eff);

    assign cur_wide    = SUM_W'(cur_val_reg);
    assign strike_wide = $signed({{(SUM_W - epo_pkg::PRICE_W){1'b0}}, cfg.strike_price});
    assign pay         = (cfg.kind == epo_pkg::KIND_PUT) ? strike_wide - cur_wide
                                                          : cur_wide - strike_wide;
    assign upay_next   = (pay < 0) ? '0 :
                         ((pay > PAY_MAX) ? '1 : pay[epo_pkg::PAYOFF_W-1:0]);
    assign sq_next     = upay_reg * upay_reg;

    // sums stay below 2^64, so bit 63 flags a saturating total
    assign pay_sum      = {1'b0, pay_acc_reg} + SUM_W'(upay_reg);
    assign sq_sum       = {1'b0, sq_acc_reg} + SUM_W'(sq_reg);
    assign pay_acc_next = pay_sum[SUM_W-1] ? '1 : pay_sum[epo_pkg::ACC_W-1:0];
    assign sq_acc_next  = sq_sum[SUM_W-1] ? '1 : sq_sum[epo_pkg::ACC_W-1:0];

    assign final_next = (cur_wide > FV_MAX) ? epo_pkg::FINAL_W'(FV_MAX) :
                        ((cur_wide < FV_MIN) ? epo_pkg::FINAL_W'(FV_MIN) :
                         epo_pkg::FINAL_W'(cur_wide));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_idx_reg <= '0;
            pay_acc_reg  <= '0;
            sq_acc_reg   <= '0;
            paths_reg    <= '0;
            origin_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.update) begin
                step_idx_reg <= path_end ? '0 : step_inc;
                if ((nv_sat <= 0) && (origin_reg != '1)) begin
                    origin_reg <= origin_reg + 1'b1;
                end
            end
            if (cmd.emit) begin
                pay_acc_reg <= pay_acc_next;
                sq_acc_reg  <= sq_acc_next;
                if (paths_reg != '1) begin
                    paths_reg <= paths_reg + 1'b1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_normal_sample;
        end
        if (cmd.cap_drift) begin
            drift_term_reg <= A_W'(p_q30);
        end
        if (cmd.cap_term) begin
            diff_term_reg <= epo_pkg::TERM_W'(term_clamped);
        end
        if (cmd.update) begin
            cur_val_reg <= VALUE_WIDTH'(nv_sat);
        end
        if (cmd.form_payoff) begin
            upay_reg <= upay_next;
        end
        if (cmd.form_square) begin
            sq_reg <= sq_next;
        end
        // snapshot the origin count so the waiting item holds still while steps go on
        if (cmd.emit) begin
            m_pay_reg    <= upay_reg;
            m_final_reg  <= final_next;
            m_origin_reg <= origin_reg;
        end
    end

    assign status.mul_done = mul_done;
    assign status.path_end = path_end;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid               = m_valid_reg;
    assign m_path_payoff         = m_pay_reg;
    assign m_final_value         = m_final_reg;
    assign m_payoff_total        = pay_acc_reg;
    assign m_payoff_square_total = sq_acc_reg;
    assign m_paths_done          = paths_reg;
    assign m_origin_hit_total    = m_origin_reg;

endmodule

### src/epo_ctrl.sv
// Controller: sequences the three multiplies, the update and the path-end work.
module epo_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output epo_pkg::cmd_t    cmd,
    input  epo_pkg::status_t status
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_WAIT_A  = 8'b0000_0010,
        S_WAIT_D  = 8'b0000_0100,
        S_WAIT_B  = 8'b0000_1000,
        S_UPDATE  = 8'b0001_0000,
        S_PAYOFF  = 8'b0010_0000,
        S_SQUARE  = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_sel     = epo_pkg::SEL_DRIFT;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    cmd.mul_start   = 1'b1;
                    state_next      = S_WAIT_A;
                end
            end
            S_WAIT_A: begin
                if (status.mul_done) begin
                    cmd.cap_drift = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = epo_pkg::SEL_DIFFUSION;
                    state_next    = S_WAIT_D;
                end
            end
            S_WAIT_D: begin
                // diffusion product feeds straight into the sample multiply
                if (status.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = epo_pkg::SEL_SAMPLE;
                    state_next    = S_WAIT_B;
                end
            end
            S_WAIT_B: begin
                if (status.mul_done) begin
                    cmd.cap_term = 1'b1;
                    state_next   = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.path_end ? S_PAYOFF : S_IDLE;
            end
            S_PAYOFF: begin
                cmd.form_payoff = 1'b1;
                state_next      = S_SQUARE;
            end
            S_SQUARE: begin
                cmd.form_square = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.mul_done |-> (state_reg == S_WAIT_A || state_reg == S_WAIT_D ||
                             state_reg == S_WAIT_B))
        else $error("multiplier done outside a wait state");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result loaded over an untaken item");

    a_no_early_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |=> !status.mul_done)
        else $error("multiplier done one cycle after start");
`endif

endmodule

### src/euler_path_option_payoff.sv
// Top level of the Euler path option payoff block.
//
// Each item on the s_ channel is one Q4.12 normal sample and advances the
// current price path by one Euler step. After steps_per_path steps the call
// or put payoff is formed and one result item goes out on the m_ channel with
// the payoff, final value, saturating payoff and payoff-square totals, and the
// path and origin-hit counts. Steps that do not end a path give no result.
// Registers sit behind the APB-style port at byte address 4*index; pready is
// always high, and they should be written only while the block is idle.
// The three chained passes through the one digit-serial multiplier, each over
// NDIG = ceil((VALUE_WIDTH+2)/32) digits, set the pace of a step; s_ready stays
// low until the item is done, so no new item is taken while one is in work. A
// path-ending item goes through payoff, square and load before m_valid rises.
// The result sits in an output register, so the next item is taken while it
// waits; if the receiver still stalls when the following path ends, the block
// holds that path's result and takes no item until the register frees.
// Reset (synchronous, active low) restores the register defaults, clears the
// totals and counters and starts a fresh path; no result is pending.
module euler_path_option_payoff #(
    parameter int VALUE_WIDTH      = 32,
    parameter int SAMPLE_WIDTH     = 16,
    parameter int STEP_COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [epo_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [epo_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [epo_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_normal_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [epo_pkg::PAYOFF_W-1:0]        m_path_payoff,
    output logic signed [epo_pkg::FINAL_W-1:0]  m_final_value,
    output logic [epo_pkg::ACC_W-1:0]           m_payoff_total,
    output logic [epo_pkg::ACC_W-1:0]           m_payoff_square_total,
    output logic [epo_pkg::CNT_W-1:0]           m_paths_done,
    output logic [epo_pkg::CNT_W-1:0]           m_origin_hit_total
);

    epo_pkg::cfg_t               cfg;
    logic [STEP_COUNT_WIDTH-1:0] steps;
    epo_pkg::cmd_t               cmd;
    epo_pkg::status_t            status;

    epo_regs #(
        .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .steps   (steps)
    );

    epo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    epo_dp #(
        .VALUE_WIDTH      (VALUE_WIDTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .cfg                   (cfg),
        .steps                 (steps),
        .s_normal_sample       (s_normal_sample),
        .m_ready               (m_ready),
        .m_valid               (m_valid),
        .m_path_payoff         (m_path_payoff),
        .m_final_value         (m_final_value),
        .m_payoff_total        (m_payoff_total),
        .m_payoff_square_total (m_payoff_square_total),
        .m_paths_done          (m_paths_done),
        .m_origin_hit_total    (m_origin_hit_total)
    );

endmodule

### tb/sv/epo_payoff_checker.sv
// Checker for the Euler path option payoff block: predicts each path result and compares it.
`timescale 1ns / 1ps

module epo_payoff_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [epo_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [epo_pkg::CFG_DATA_W-1:0]      pwdata,
    input  logic                                pready,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_normal_sample,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [epo_pkg::PAYOFF_W-1:0]        m_path_payoff,
    input  logic signed [epo_pkg::FINAL_W-1:0]  m_final_value,
    input  logic [epo_pkg::ACC_W-1:0]           m_payoff_total,
    input  logic [epo_pkg::ACC_W-1:0]           m_payoff_square_total,
    input  logic [epo_pkg::CNT_W-1:0]           m_paths_done,
    input  logic [epo_pkg::CNT_W-1:0]           m_origin_hit_total,
    output int                                  mismatch_count,
    output int                                  due_count,
    output int                                  paths_checked
);
    import epo_pkg::*;

    localparam logic signed [63:0] VALUE_HI  = 64'sd2147483647;
    localparam logic signed [63:0] VALUE_LO  = -64'sd2147483648;
    localparam logic signed [63:0] PAYOFF_HI = 64'sd2147483647;
    localparam logic [63:0]        ACC_HI    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0]   CNT_HI    = '1;
    localparam logic [127:0]       TERM_CAP  = 128'd1 << TERM_SHIFT;

    typedef struct {
        logic [PAYOFF_W-1:0]        payoff;
        logic signed [FINAL_W-1:0]  final_value;
        logic [ACC_W-1:0]           payoff_total;
        logic [ACC_W-1:0]           square_total;
        logic [CNT_W-1:0]           paths;
        logic [CNT_W-1:0]           origin_hits;
    } path_result_t;

    path_result_t path_results_due[$];

    // register copies
    logic signed [FACTOR_W-1:0] drift_q30;
    logic signed [FACTOR_W-1:0] diffusion_q30;
    logic [PRICE_W-1:0]         start_q16;
    logic [PRICE_W-1:0]         strike_q16;
    kind_t                      option_kind;
    logic [15:0]                path_length;

    // path state
    logic signed [63:0]         price_q16;
    int                         step_in_path;
    logic [ACC_W-1:0]           payoff_sum;
    logic [ACC_W-1:0]           square_sum;
    logic [CNT_W-1:0]           path_count;
    logic [CNT_W-1:0]           origin_count;

    initial begin
        mismatch_count = 0;
        due_count      = 0;
        paths_checked  = 0;
    end

    // floor(x*y / 2^shift), magnitude capped at 2^TERM_SHIFT
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] x,
                                                          input logic signed [63:0] y,
                                                          input int shift);
        logic         negative;
        logic [63:0]  ux;
        logic [63:0]  uy;
        logic [127:0] mag;
        negative = (x < 0) != (y < 0);
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        mag = {64'd0, ux} * {64'd0, uy};
        // round the magnitude up so the negative result lands on the floor
        if (negative) mag = mag + ((128'd1 << shift) - 128'd1);
        mag = mag >> shift;
        if (mag > TERM_CAP) mag = TERM_CAP;
        return negative ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    function automatic logic [ACC_W-1:0] add_capped(input logic [ACC_W-1:0] total,
                                                    input logic [63:0] addend);
        logic [63:0] sum;
        sum = 64'(total) + addend;
        return (sum > ACC_HI) ? ACC_HI[ACC_W-1:0] : sum[ACC_W-1:0];
    endfunction

    task automatic clear_model();
        drift_q30     = '0;
        diffusion_q30 = '0;
        start_q16     = START_RESET;
        strike_q16    = STRIKE_RESET;
        option_kind   = KIND_CALL;
        path_length   = 16'(STEPS_RESET);
        price_q16     = 64'(START_RESET);
        step_in_path  = 0;
        payoff_sum    = '0;
        square_sum    = '0;
        path_count    = '0;
        origin_count  = '0;
        path_results_due.delete();
    endtask

    task automatic advance_path(input logic signed [SAMPLE_WIDTH-1:0] sample);
        logic signed [63:0] base;
        logic signed [63:0] drift_term;
        logic signed [63:0] spread;
        logic signed [63:0] shock;
        logic signed [63:0] next_value;
        logic signed [63:0] strike_wide;
        logic signed [63:0] gain;
        int                 path_end;
        path_result_t       res;
        // a fresh path starts from the start price as it is now
        base = (step_in_path == 0) ? $signed(64'(start_q16)) : price_q16;
        drift_term = scaled_product(base, drift_q30, FACTOR_FRAC);
        spread     = scaled_product(base, diffusion_q30, FACTOR_FRAC);
        shock      = scaled_product(spread, sample, SAMPLE_FRAC);
        next_value = base + drift_term + shock;
        if (next_value > VALUE_HI) next_value = VALUE_HI;
        if (next_value < VALUE_LO) next_value = VALUE_LO;
        price_q16 = next_value;
        if (next_value <= 0 && origin_count != CNT_HI) origin_count = origin_count + 1'b1;
        step_in_path++;
        path_end = (path_length == 0) ? 1 : int'(path_length);
        if (step_in_path >= path_end) begin
            step_in_path = 0;
            strike_wide = $signed(64'(strike_q16));
            gain = (option_kind == KIND_PUT) ? strike_wide - next_value
                                             : next_value - strike_wide;
            if (gain < 0) gain = 0;
            if (gain > PAYOFF_HI) gain = PAYOFF_HI;
            payoff_sum = add_capped(payoff_sum, gain);
            square_sum = add_capped(square_sum, gain * gain);
            if (path_count != CNT_HI) path_count = path_count + 1'b1;
            res.payoff       = gain[PAYOFF_W-1:0];
            res.final_value  = next_value[FINAL_W-1:0];
            res.payoff_total = payoff_sum;
            res.square_total = square_sum;
            res.paths        = path_count;
            res.origin_hits  = origin_count;
            path_results_due.insert(path_results_due.size(), res);
        end
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_result();
        path_result_t want;
        if (path_results_due.size() == 0) begin
            $error("result item arrived with no finished path expected");
            mismatch_count++;
        end else begin
            want = path_results_due.pop_front();
            check_field("path_payoff", want.payoff, m_path_payoff);
            check_field("final_value", want.final_value, m_final_value);
            check_field("payoff_total", want.payoff_total, m_payoff_total);
            check_field("payoff_square_total", want.square_total, m_payoff_square_total);
            check_field("paths_done", want.paths, m_paths_done);
            check_field("origin_hit_total", want.origin_hits, m_origin_hit_total);
            paths_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (psel && penable && pwrite && pready) begin
                // unknown indexes fall through and are dropped
                case (paddr[CFG_ADDR_W-1:REG_IDX_LSB])
                    REG_DRIFT:     drift_q30     = pwdata;
                    REG_DIFFUSION: diffusion_q30 = pwdata;
                    REG_START:     start_q16     = pwdata[PRICE_W-1:0];
                    REG_STRIKE:    strike_q16    = pwdata[PRICE_W-1:0];
                    REG_KIND:      option_kind   = kind_t'(pwdata[0]);
                    REG_STEPS:     path_length   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) compare_result();
            if (s_valid && s_ready) advance_path(s_normal_sample);
        end
        due_count = path_results_due.size();
    end

endmodule

### tb/sv/euler_path_option_payoff_test.sv
// Top of the Euler path option payoff testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module euler_path_option_payoff_test;
    import epo_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    // leave ample room after the last item for its step and any path-end work
    localparam int SETTLE_CYCLES = 40;
    // the limit sits far above the slowest correct gap: item work, a stall and a gap
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 1250;
    localparam logic [31:0] Q16_ONE     = 32'd65536;
    localparam logic [31:0] PRICE_TOP   = 32'h7FFF_FFFF;
    localparam logic [31:0] FACTOR_TOP  = 32'h7FFF_FFFF;
    localparam logic [31:0] FACTOR_BOT  = 32'h8000_0000;
    localparam logic [2:0]  UNUSED_INDEX = 3'd6;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]      paddr = '0;
    logic [CFG_DATA_W-1:0]      pwdata = '0;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [15:0]         s_normal_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [PAYOFF_W-1:0]        m_path_payoff;
    logic signed [FINAL_W-1:0]  m_final_value;
    logic [ACC_W-1:0]           m_payoff_total;
    logic [ACC_W-1:0]           m_payoff_square_total;
    logic [CNT_W-1:0]           m_paths_done;
    logic [CNT_W-1:0]           m_origin_hit_total;

    int mismatch_count;
    int due_count;
    int paths_checked;
    int items_sent = 0;
    int phase_count = 0;
    int idle_cycles = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    euler_path_option_payoff u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_normal_sample       (s_normal_sample),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_path_payoff         (m_path_payoff),
        .m_final_value         (m_final_value),
        .m_payoff_total        (m_payoff_total),
        .m_payoff_square_total (m_payoff_square_total),
        .m_paths_done          (m_paths_done),
        .m_origin_hit_total    (m_origin_hit_total)
    );

    epo_payoff_checker u_checker (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .pready                (pready),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_normal_sample       (s_normal_sample),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_path_payoff         (m_path_payoff),
        .m_final_value         (m_final_value),
        .m_payoff_total        (m_payoff_total),
        .m_payoff_square_total (m_payoff_square_total),
        .m_paths_done          (m_paths_done),
        .m_origin_hit_total    (m_origin_hit_total),
        .mismatch_count        (mismatch_count),
        .due_count             (due_count),
        .paths_checked         (paths_checked)
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("euler_path_option_payoff: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: hold m_ready low for a random pause before taking each item, with no pause in a burst
    initial begin : result_sink
        int pause;
        @(posedge aresetn);
        forever begin
            pause = recv_burst ? 0 : $urandom_range(0, 8);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) << REG_IDX_LSB);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] z);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_normal_sample <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // drop valid, wait for every finished path, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (due_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        phase_count++;
    endtask

    initial begin : stimulus
        logic [31:0] drift;
        logic [31:0] diffusion;
        logic [31:0] start;
        logic [31:0] strike;
        logic [31:0] steps;
        logic [15:0] z;
        int          pick;
        int          burst_len;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // top payoff on every path: the square total saturates on the third
        write_register(REG_DRIFT, 32'd0);
        write_register(REG_DIFFUSION, 32'd0);
        write_register(REG_START, PRICE_TOP);
        write_register(REG_STRIKE, 32'd0);
        write_register(REG_KIND, 32'(KIND_CALL));
        write_register(REG_STEPS, 32'd1);
        write_register(UNUSED_INDEX, 32'hFFFF_FFFF);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        settle();

        // zero steps acts as one; put on a negative value saturates
        write_register(REG_STEPS, 32'd0);
        write_register(REG_DRIFT, FACTOR_TOP);
        write_register(REG_DIFFUSION, FACTOR_BOT);
        write_register(REG_START, 32'd100 * Q16_ONE);
        write_register(REG_STRIKE, PRICE_TOP);
        write_register(REG_KIND, 32'(KIND_PUT));
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        settle();

        // path pinned at the origin
        write_register(REG_START, 32'd0);
        write_register(REG_STRIKE, 32'd0);
        write_register(REG_KIND, 32'(KIND_CALL));
        write_register(REG_DRIFT, FACTOR_BOT);
        write_register(REG_DIFFUSION, FACTOR_TOP);
        write_register(REG_STEPS, 32'd1);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        settle();

        // value clamps at the top of its range
        write_register(REG_START, PRICE_TOP);
        write_register(REG_DRIFT, FACTOR_TOP);
        write_register(REG_DIFFUSION, 32'd0);
        write_register(REG_STEPS, 32'd2);
        send_sample(16'd1234);
        send_sample(-16'sd1234);
        settle();

        // longest path cut short; the new start price waits for the next path
        write_register(REG_DRIFT, 32'd178957);
        write_register(REG_DIFFUSION, 32'd12398000);
        write_register(REG_START, 32'd100 * Q16_ONE);
        write_register(REG_STRIKE, 32'd100 * Q16_ONE);
        write_register(REG_STEPS, 32'd65535);
        send_sample(16'd4096);
        send_sample(-16'sd4096);
        send_sample(16'd2048);
        settle();
        write_register(REG_START, 32'd50 * Q16_ONE);
        write_register(REG_STEPS, 32'd2);
        send_sample(-16'sd8192);
        send_sample(16'd8192);
        send_sample(-16'sd2048);
        settle();

        while (items_sent < RANDOM_ITEMS + 16) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // market-like: small factors, strike near the start price
                drift = $urandom_range(0, 600000);
                if ($urandom_range(0, 3) == 0) drift = -drift;
                diffusion = $urandom_range(0, 60000000);
                if ($urandom_range(0, 3) == 0) diffusion = -diffusion;
                start  = ($urandom_range(20, 200) << 16) | $urandom_range(0, 65535);
                strike = start + ($urandom_range(0, 40) << 16) - (32'd20 << 16);
            end else begin
                drift     = $urandom();
                diffusion = $urandom();
                start     = $urandom() & PRICE_TOP;
                strike    = $urandom() & PRICE_TOP;
            end
            pick = $urandom_range(0, 15);
            if (pick == 0) steps = 32'd0;
            else if (pick < 12) steps = $urandom_range(1, 8);
            else steps = $urandom_range(9, 48);
            write_register(REG_DRIFT, drift);
            write_register(REG_DIFFUSION, diffusion);
            write_register(REG_START, start);
            write_register(REG_STRIKE, strike);
            write_register(REG_KIND, $urandom_range(0, 1));
            write_register(REG_STEPS, steps);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            burst_len  = $urandom_range(10, 40);
            repeat (burst_len) begin
                if ($urandom_range(0, 3) == 0) z = $urandom();
                else z = 16'($urandom_range(0, 24576) - 12288);
                send_sample(z);
            end
            settle();
        end

        $display("covered %0d samples over %0d register settings, %0d finished paths checked",
                 items_sent, phase_count, paths_checked);
        if (mismatch_count == 0 && due_count == 0) begin
            $display("euler_path_option_payoff: match");
        end else begin
            $display("euler_path_option_payoff: mismatch");
        end
        $finish;
    end

endmodule
